/* rtl/core/jfc_pkg.sv */
package jfc_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam int unsigned KeyWidth   = 16;
  localparam int unsigned PagesWidth = 16;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned StatusWidth = 3;

  localparam logic [PagesWidth-1:0] PageLimitReset = 16'd50;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_CANCEL  = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [StatusWidth-1:0] ST_OK       = 3'd0;
  localparam logic [StatusWidth-1:0] ST_PAGES    = 3'd1;
  localparam logic [StatusWidth-1:0] ST_FULL     = 3'd2;
  localparam logic [StatusWidth-1:0] ST_EMPTY    = 3'd3;
  localparam logic [StatusWidth-1:0] ST_NOTFOUND = 3'd4;

endpackage

/* rtl/core/job_fifo_with_cancel.sv */
// Job queue with cancel by key.
// Input channel (in_valid_i/in_ready_o) carries one operation per transfer:
// enqueue, dequeue, cancel by key or clear. The output channel
// (out_valid_o/out_ready_i) returns exactly one result per operation, in order.
// The page limit is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Jobs live in a single-port-write, registered-read memory of DEPTH words.
// Enqueue, clear and any refused operation present their result in the cycle
// after the transfer. Dequeue waits for the registered memory read. Cancel
// streams through the held jobs at one per cycle, compacting survivors in place.
// A new operation is taken when the controller is idle and the output register
// is empty or being emptied in the same cycle; a stalled receiver therefore
// holds off further operations while its result waits.
// Reset empties the queue, drops any pending result and sets the page limit to
// 50; the memory contents are not cleared.
module job_fifo_with_cancel #(
  parameter int unsigned DEPTH = jfc_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jfc_pkg::PagesWidth-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [jfc_pkg::KeyWidth-1:0]        doc_key_i,
  input  logic [jfc_pkg::PagesWidth-1:0]      page_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [jfc_pkg::StatusWidth-1:0]     status_o,
  output logic [jfc_pkg::KeyWidth-1:0]        job_key_o,
  output logic [jfc_pkg::PagesWidth-1:0]      job_pages_o,
  output logic [jfc_pkg::CountWidth-1:0]      job_count_o
);
  import jfc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = (AW + 1 > CountWidth) ? AW + 1 : CountWidth;
  localparam int unsigned DW = KeyWidth + PagesWidth;
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
  localparam logic [CW-1:0] CountMax = CW'((1 << CountWidth) - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DEQ    = 2'd1;
  localparam logic [1:0] S_CANCEL = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]         rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic                  pend_q, pend_d, hit_q, hit_d;
  logic [KeyWidth-1:0]   cancel_key_q, cancel_key_d;
  logic [PagesWidth-1:0] page_limit_q;

  logic                   out_valid_q, out_valid_d;
  logic [StatusWidth-1:0] status_q, status_d;
  logic [KeyWidth-1:0]    job_key_q, job_key_d;
  logic [PagesWidth-1:0]  job_pages_q, job_pages_d;
  logic [CountWidth-1:0]  job_count_q;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  logic          in_xfer, out_free, load_out, empty, full;
  logic [CW-1:0] count_next;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LastSlot) ? '0 : p + 1'b1;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign empty      = (head_q == tail_q);
  assign full       = (next_slot(tail_q) == head_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    pend_d       = 1'b0;
    hit_d        = hit_q;
    cancel_key_d = cancel_key_q;
    load_out     = 1'b0;
    status_d     = ST_OK;
    job_key_d    = '0;
    job_pages_d  = '0;
    mem_we       = 1'b0;
    mem_waddr    = tail_q;
    mem_wdata    = {doc_key_i, page_count_i};
    mem_raddr    = head_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_i)
            OP_ENQUEUE: begin
              load_out = 1'b1;
              if (page_count_i > page_limit_q) begin
                status_d = ST_PAGES;
              end else if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                tail_d = next_slot(tail_q);
              end
            end
            OP_DEQUEUE: begin
              if (empty) begin
                load_out = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d = S_DEQ;
              end
            end
            OP_CANCEL: begin
              if (empty) begin
                load_out = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d      = S_CANCEL;
                rd_ptr_d     = head_q;
                wr_ptr_d     = head_q;
                hit_d        = 1'b0;
                cancel_key_d = doc_key_i;
              end
            end
            default: begin
              load_out = 1'b1;
              head_d   = '0;
              tail_d   = '0;
            end
          endcase
        end
      end
      S_DEQ: begin
        load_out    = 1'b1;
        job_key_d   = rdata_q[DW-1:PagesWidth];
        job_pages_d = rdata_q[PagesWidth-1:0];
        head_d      = next_slot(head_q);
        state_d     = S_IDLE;
      end
      S_CANCEL: begin
        mem_raddr = rd_ptr_q;
        mem_waddr = wr_ptr_q;
        mem_wdata = rdata_q;
        if (rd_ptr_q != tail_q) begin
          rd_ptr_d = next_slot(rd_ptr_q);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          if (rdata_q[DW-1:PagesWidth] == cancel_key_q) begin
            hit_d = 1'b1;
          end else begin
            mem_we   = 1'b1;
            wr_ptr_d = next_slot(wr_ptr_q);
          end
        end else if (rd_ptr_q == tail_q) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
          if (hit_q) begin
            tail_d = wr_ptr_q;
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (tail_d >= head_d) begin
      count_next = CW'(tail_d) - CW'(head_d);
    end else begin
      count_next = CW'(tail_d) + DepthC - CW'(head_d);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      pend_q       <= 1'b0;
      hit_q        <= 1'b0;
      page_limit_q <= PageLimitReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        page_limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cancel_key_q <= cancel_key_d;
    if (load_out) begin
      status_q    <= status_d;
      job_key_q   <= job_key_d;
      job_pages_q <= job_pages_d;
      job_count_q <= (count_next > CountMax) ? CountMax[CountWidth-1:0]
                                             : count_next[CountWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign job_key_o   = job_key_q;
  assign job_pages_o = job_pages_q;
  assign job_count_o = job_count_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input taken while an operation is in progress");

  a_cancel_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CANCEL |-> !out_valid_q)
    else $error("result pending during a cancel pass");

  a_deq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEQ |=> out_valid_o && status_o == ST_OK)
    else $error("dequeue did not present its job");

  a_page_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op_i == OP_ENQUEUE && page_count_i > page_limit_q
    |=> out_valid_o && status_o == ST_PAGES)
    else $error("oversized job not refused");

  a_cancel_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CANCEL && !hit_q |-> wr_ptr_q == rd_ptr_q || pend_q)
    else $error("compaction pointer ran ahead without a match");

endmodule

/* tb/tb_job_fifo_with_cancel.sv */
`timescale 1ns / 1ps

module tb_job_fifo_with_cancel;
  import jfc_pkg::*;

  localparam int Depth = DepthDefault;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [KeyWidth-1:0]    job_key;
    logic [PagesWidth-1:0]  job_pages;
    logic [CountWidth-1:0]  job_count;
  } job_result_t;

  class job_queue_scoreboard;
    logic [KeyWidth-1:0]   key_mem[Depth];
    logic [PagesWidth-1:0] pages_mem[Depth];
    int                    head;
    int                    tail;
    logic [PagesWidth-1:0] page_limit;
    job_result_t           awaited[$];
    int                    mismatches;

    function new();
      head       = 0;
      tail       = 0;
      page_limit = PageLimitReset;
      mismatches = 0;
    endfunction

    function void set_page_limit(logic [PagesWidth-1:0] value);
      page_limit = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_op(logic [1:0] op, logic [KeyWidth-1:0] key,
                          logic [PagesWidth-1:0] pages);
      job_result_t           res;
      logic [KeyWidth-1:0]   kept_keys[Depth];
      logic [PagesWidth-1:0] kept_pages[Depth];
      int                    kept;
      int                    idx;
      bit                    hit;
      int                    held;
      res = '0;
      res.status = ST_OK;
      case (op)
        OP_ENQUEUE: begin
          if (pages > page_limit) begin
            res.status = ST_PAGES;
          end else if ((tail + 1) % Depth == head) begin
            res.status = ST_FULL;
          end else begin
            key_mem[tail]   = key;
            pages_mem[tail] = pages;
            tail = (tail + 1) % Depth;
          end
        end
        OP_DEQUEUE: begin
          if (head == tail) begin
            res.status = ST_EMPTY;
          end else begin
            res.job_key   = key_mem[head];
            res.job_pages = pages_mem[head];
            head = (head + 1) % Depth;
          end
        end
        OP_CANCEL: begin
          if (head == tail) begin
            res.status = ST_EMPTY;
          end else begin
            kept = 0;
            hit  = 1'b0;
            idx  = head;
            while (idx != tail) begin
              if (key_mem[idx] == key) begin
                hit = 1'b1;
              end else begin
                kept_keys[kept]  = key_mem[idx];
                kept_pages[kept] = pages_mem[idx];
                kept++;
              end
              idx = (idx + 1) % Depth;
            end
            if (!hit) begin
              res.status = ST_NOTFOUND;
            end else begin
              for (int j = 0; j < kept; j++) begin
                key_mem[j]   = kept_keys[j];
                pages_mem[j] = kept_pages[j];
              end
              head = 0;
              tail = kept;
            end
          end
        end
        default: begin
          head = 0;
          tail = 0;
        end
      endcase
      held = (tail - head + Depth) % Depth;
      if (held > 15) held = 15;
      res.job_count = CountWidth'(held);
      awaited.push_back(res);
    endfunction

    function void check_result(job_result_t got);
      job_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no transfer outstanding: status %0d key %h",
                   $realtime, got.status, got.job_key,
                   " pages %h count %0d", got.job_pages, got.job_count);
        return;
      end
      want = awaited.pop_front();
      if (got.status != want.status || got.job_key != want.job_key ||
          got.job_pages != want.job_pages || got.job_count != want.job_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  status    expected %0d actual %0d", want.status, got.status);
          $display("  job_key   expected %h actual %h", want.job_key, got.job_key);
          $display("  job_pages expected %h actual %h", want.job_pages, got.job_pages);
          $display("  job_count expected %0d actual %0d", want.job_count, got.job_count);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [PagesWidth-1:0]  cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             op_i;
  logic [KeyWidth-1:0]    doc_key_i;
  logic [PagesWidth-1:0]  page_count_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [StatusWidth-1:0] status_o;
  logic [KeyWidth-1:0]    job_key_o;
  logic [PagesWidth-1:0]  job_pages_o;
  logic [CountWidth-1:0]  job_count_o;

  job_queue_scoreboard sb = new();

  bit                    calm;
  bit                    stall_request;
  logic [PagesWidth-1:0] current_limit;
  logic [KeyWidth-1:0]   key_pool[6];

  job_fifo_with_cancel dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .doc_key_i    (doc_key_i),
    .page_count_i (page_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .job_key_o    (job_key_o),
    .job_pages_o  (job_pages_o),
    .job_count_o  (job_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result({status_o, job_key_o, job_pages_o, job_count_o});
      if (in_valid_i && in_ready_o)
        sb.note_op(op_i, doc_key_i, page_count_i);
    end
  end

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  initial begin
    int hold_left;
    int pressure_left;
    hold_left     = 0;
    pressure_left = 0;
    out_ready_i   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        pressure_left = 120;
        stall_request = 1'b0;
      end
      if (pressure_left > 0) begin
        out_ready_i <= 1'b0;
        pressure_left--;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if ($urandom_range(0, 99) < 65) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        hold_left = stall_length() - 1;
      end
    end
  end

  task automatic send_op(logic [1:0] op, logic [KeyWidth-1:0] key,
                         logic [PagesWidth-1:0] pages);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 8);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    op_i         <= op;
    doc_key_i    <= key;
    page_count_i <= pages;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  task automatic write_page_limit(logic [PagesWidth-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_page_limit(value);
    current_limit = value;
  endtask

  task automatic random_op(int enqueue_weight);
    int                    r;
    logic [1:0]            op;
    logic [KeyWidth-1:0]   key;
    logic [PagesWidth-1:0] pages;
    r = $urandom_range(0, 99);
    if (r < enqueue_weight) op = OP_ENQUEUE;
    else if (r < enqueue_weight + 22) op = OP_DEQUEUE;
    else if (r < 97) op = OP_CANCEL;
    else op = OP_CLEAR;
    if ($urandom_range(0, 99) < 70) key = key_pool[$urandom_range(0, 5)];
    else key = KeyWidth'($urandom);
    if ($urandom_range(0, 99) < 75) pages = PagesWidth'($urandom_range(0, current_limit));
    else pages = PagesWidth'($urandom);
    send_op(op, key, pages);
  endtask

  initial begin
    logic [PagesWidth-1:0] limits[5];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    op_i          = OP_CLEAR;
    doc_key_i     = '0;
    page_count_i  = '0;
    calm          = 1'b0;
    stall_request = 1'b0;
    current_limit = PageLimitReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_op(OP_DEQUEUE, 16'h0000, 16'h0000);
    send_op(OP_CANCEL, 16'hFFFF, 16'h0000);
    send_op(OP_ENQUEUE, 16'hFFFF, 16'd50);
    send_op(OP_ENQUEUE, 16'h0000, 16'd51);
    send_op(OP_ENQUEUE, 16'h0000, 16'h0000);
    send_op(OP_ENQUEUE, 16'h8000, 16'hFFFF);
    for (int i = 0; i < 13; i++)
      send_op(OP_ENQUEUE, (i % 2 == 0) ? 16'h0001 : 16'h0002, PagesWidth'(50 - i));
    send_op(OP_ENQUEUE, 16'h0003, 16'd1);
    send_op(OP_ENQUEUE, 16'h0003, 16'd60);
    send_op(OP_CANCEL, 16'h1234, 16'h0000);
    send_op(OP_CANCEL, 16'h0001, 16'h0000);
    send_op(OP_DEQUEUE, 16'h0000, 16'h0000);
    send_op(OP_CLEAR, 16'hFFFF, 16'hFFFF);

    limits[0] = 16'd0;
    limits[1] = 16'hFFFF;
    limits[2] = PagesWidth'($urandom);
    limits[3] = PagesWidth'($urandom_range(1, 200));
    limits[4] = PageLimitReset;
    for (int phase = 0; phase < 5; phase++) begin
      write_page_limit(limits[phase]);
      for (int k = 0; k < 6; k++) key_pool[k] = KeyWidth'($urandom);
      for (int n = 0; n < 166; n++) begin
        calm = (phase == 1 && n < 60);
        if (phase == 2 && n == 40) stall_request = 1'b1;
        random_op((n / 30) % 2 == 0 ? 58 : 35);
      end
      calm = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int w = 0; w < 20000 && sb.pending() > 0; w++) @(posedge clk_i);
    repeat (Depth * 3) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/jfc_pkg.sv
rtl/core/job_fifo_with_cancel.sv
tb/tb_job_fifo_with_cancel.sv
